// File: hdl/i2c_master_bit_sequencer_core_assert.svh
// Assertion macros shared by the I2C bit sequencer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTH

// Concurrent property check, disabled while reset is asserted.
`define I2CBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same-cycle implication check built on the macro above.
`define I2CBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `I2CBS_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication check built on the first macro.
`define I2CBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `I2CBS_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`else

`define I2CBS_ASSERT(lbl, clk, rstn, prop)
`define I2CBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define I2CBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/i2cbs_pkg.sv
// Shared types, constants and helpers for the I2C master bit sequencer.
// No dependencies; imported by the sequencer and the top level.
package i2cbs_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned PhaseW      = 5;
  localparam logic [15:0] PhaseTicksReset = 16'd10;

  // Command codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_STOP    = 3'd1,
    MODE_TX_BYTE = 3'd2,
    MODE_RX_BYTE = 3'd3,
    MODE_TX_ACK  = 3'd4,
    MODE_RX_ACK  = 3'd5
  } mode_e;

  // Register map (word index).
  localparam logic RegPhaseTicks = 1'b0;

  // One tick's input item.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       tx_ack;
    logic       sda_in;
  } item_t;

  // One tick's result item.
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       rx_ack;
    logic       cmd_dropped;
  } res_t;

  // Number of line phases in each command's run.
  function automatic logic [PhaseW-1:0] run_length(mode_e m);
    logic [PhaseW-1:0] len;
    unique case (m)
      MODE_START:   len = PhaseW'(4);
      MODE_STOP:    len = PhaseW'(3);
      MODE_TX_BYTE: len = PhaseW'(3 * BitsPerByte);
      MODE_RX_BYTE: len = PhaseW'(1 + 3 * BitsPerByte);
      MODE_TX_ACK:  len = PhaseW'(3);
      MODE_RX_ACK:  len = PhaseW'(4);
      default:      len = '0;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: stream ports, APB register port
// and two-entry result buffer. Depends on i2cbs_pkg, i2cbs_seq, the assert header.
//
//  Channel   Direction  Handshake                 Contents
//  s_axis    in         tvalid/tready             one tick: command fields, sda_in
//  m_axis    out        tvalid/tready             one result per tick: lines, status
//  apb       in/out     psel/penable/pready       phase_ticks at address 0
//
// The sequencer updates its state in the cycle each tick is transferred and the
// result is registered behind it.
// A result buffer of two entries lets a tick be taken while one result waits.
// Reset is asynchronous and active low: lines released, idle, phase_ticks 10.
// s_axis_tready drops only while both result entries are full.
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2c_master_bit_sequencer_core
  import i2cbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] tx_byte, [8] tx_ack, [9] sda_in, [15:10] zero
  input  logic [15:0] s_axis_tdata,
  // [0] cmd_valid, [3:1] mode
  input  logic [3:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] rx_ack, [13] cmd_dropped, [15:14] zero
  output logic [15:0] m_axis_tdata,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] phase_ticks_q;
  logic [15:0] hold;
  logic        cfg_write;
  logic        in_accept;
  logic        out_pop;
  item_t       item;
  res_t        res;
  res_t        out_q;
  res_t        skid_q;
  logic        out_valid_q;
  logic        skid_valid_q;

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegPhaseTicks) ? {16'h0000, phase_ticks_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_write && (paddr[2] == RegPhaseTicks)) begin
      phase_ticks_q <= pwdata[15:0];
    end
  end

  // A zero hold time behaves like one tick.
  assign hold = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;

  // Input unpacking.
  assign s_axis_tready = !skid_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign item = '{
    cmd_valid: s_axis_tuser[0],
    mode:      s_axis_tuser[3:1],
    tx_byte:   s_axis_tdata[7:0],
    tx_ack:    s_axis_tdata[8],
    sda_in:    s_axis_tdata[9]
  };

  i2cbs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_accept),
    .item_i (item),
    .hold_i (hold),
    .res_o  (res)
  );

  // Result buffer: output register plus one skid entry.
  assign out_pop = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_q) begin
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        out_q <= res;
      end else begin
        out_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_q) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end else begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.cmd_dropped, out_q.rx_ack, out_q.rx_byte,
                          out_q.done, out_q.busy, out_q.sda_release, out_q.scl_release};

  // The skid entry is only ever used behind a full output register.
  `I2CBS_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // A tick taken while a result waits and is not drained lands in the skid entry.
  `I2CBS_ASSERT_NEXT(a_stall_fills_skid, clk_i, rst_ni,
                     in_accept && out_valid_q && !m_axis_tready, skid_valid_q)
  // Draining with a full skid entry keeps the output register occupied.
  `I2CBS_ASSERT_NEXT(a_skid_refills_out, clk_i, rst_ni,
                     out_pop && skid_valid_q, out_valid_q && !skid_valid_q)

endmodule

// File: hdl/i2cbs_seq.sv
// Phase sequencer of the I2C master: command state, phase and tick counters,
// line levels and receive registers. Depends on i2cbs_pkg and the assert header.
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2cbs_seq
  import i2cbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  item_t       item_i,
  input  logic [15:0] hold_i,
  output res_t        res_o
);

  mode_e             mode_q, mode_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [15:0]       tick_q, tick_d;
  logic [1:0]        slot_q, slot_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic              ack_q, ack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              busy_q, busy_d;
  logic [7:0]        rx_byte_q, rx_byte_d;
  logic              rx_ack_q, rx_ack_d;
  logic              enter;
  logic              done;
  logic              dropped;

  // Next state for one tick, including the line action of a newly entered phase.
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    slot_d    = slot_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    busy_d    = busy_q;
    rx_byte_d = rx_byte_q;
    rx_ack_d  = rx_ack_q;
    enter     = 1'b0;
    done      = 1'b0;
    dropped   = 1'b0;

    if (step_i) begin
      if (busy_q) begin
        dropped = item_i.cmd_valid;
        tick_d  = tick_q + 16'd1;
        if (tick_d >= hold_i) begin
          tick_d  = '0;
          phase_d = phase_q + PhaseW'(1);
          if (phase_d >= run_length(mode_q)) begin
            busy_d = 1'b0;
            done   = 1'b1;
            if (mode_q == MODE_RX_BYTE) rx_byte_d = shift_q;
            if (mode_q == MODE_RX_ACK)  rx_ack_d  = ack_q;
          end else begin
            enter = 1'b1;
            // Slot and bit track position within the three-phase bit cell.
            if (slot_q == 2'd2) begin
              slot_d = 2'd0;
              bit_d  = bit_q + 3'd1;
            end else begin
              slot_d = slot_q + 2'd1;
            end
          end
        end
      end else if (item_i.cmd_valid && (item_i.mode <= MODE_RX_ACK)) begin
        mode_d  = mode_e'(item_i.mode);
        busy_d  = 1'b1;
        phase_d = '0;
        tick_d  = '0;
        shift_d = (item_i.mode == MODE_TX_BYTE) ? item_i.tx_byte : 8'h00;
        ack_d   = (item_i.mode == MODE_TX_ACK) ? item_i.tx_ack : 1'b0;
        // Receive byte has a leading release phase, so its first cell starts one later.
        if (item_i.mode == MODE_RX_BYTE) begin
          slot_d = 2'd2;
          bit_d  = 3'd7;
        end else begin
          slot_d = 2'd0;
          bit_d  = 3'd0;
        end
        enter = 1'b1;
      end

      // Line action on entry to a phase.
      if (enter) begin
        unique case (mode_d)
          MODE_START: begin
            if (phase_d == PhaseW'(0))      sda_d = 1'b1;
            else if (phase_d == PhaseW'(1)) scl_d = 1'b1;
            else if (phase_d == PhaseW'(2)) sda_d = 1'b0;
            else                            scl_d = 1'b0;
          end
          MODE_STOP: begin
            if (phase_d == PhaseW'(0))      sda_d = 1'b0;
            else if (phase_d == PhaseW'(1)) scl_d = 1'b1;
            else                            sda_d = 1'b1;
          end
          MODE_TX_BYTE: begin
            if (slot_d == 2'd0)      sda_d = shift_d[3'd7 - bit_d];
            else if (slot_d == 2'd1) scl_d = 1'b1;
            else                     scl_d = 1'b0;
          end
          MODE_RX_BYTE: begin
            if (phase_d == PhaseW'(0)) begin
              sda_d = 1'b1;
            end else if (slot_d == 2'd0) begin
              scl_d = 1'b1;
            end else if (slot_d == 2'd1) begin
              sda_d = 1'b1;
              if (item_i.sda_in) shift_d[3'd7 - bit_d] = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end
          MODE_TX_ACK: begin
            if (phase_d == PhaseW'(0))      sda_d = ack_d;
            else if (phase_d == PhaseW'(1)) scl_d = 1'b1;
            else                            scl_d = 1'b0;
          end
          MODE_RX_ACK: begin
            if (phase_d == PhaseW'(0)) begin
              sda_d = 1'b1;
            end else if (phase_d == PhaseW'(1)) begin
              scl_d = 1'b1;
            end else if (phase_d == PhaseW'(2)) begin
              sda_d = 1'b1;
              ack_d = item_i.sda_in;
            end else begin
              scl_d = 1'b0;
            end
          end
          default: begin
            scl_d = scl_q;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      phase_q   <= '0;
      tick_q    <= '0;
      slot_q    <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      busy_q    <= 1'b0;
      rx_byte_q <= '0;
      rx_ack_q  <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      slot_q    <= slot_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      busy_q    <= busy_d;
      rx_byte_q <= rx_byte_d;
      rx_ack_q  <= rx_ack_d;
    end
  end

  // The result reflects the state after this tick's update.
  assign res_o = '{
    scl_release: scl_d,
    sda_release: sda_d,
    busy:        busy_d,
    done:        done,
    rx_byte:     rx_byte_d,
    rx_ack:      rx_ack_d,
    cmd_dropped: dropped
  };

  // A finish or a drop can only come out of a running command.
  `I2CBS_ASSERT_IMPL(a_done_needs_busy, clk_i, rst_ni, step_i && done, busy_q)
  `I2CBS_ASSERT_IMPL(a_drop_needs_busy, clk_i, rst_ni, step_i && dropped, busy_q)
  // A running command never sits past the end of its phase run.
  `I2CBS_ASSERT_IMPL(a_phase_in_run, clk_i, rst_ni, busy_q, phase_q < run_length(mode_q))

endmodule
